// ===== rtl/core/bla_pkg.sv =====
// Shared constants and the arctangent step table for the launch angle pipeline.
package bla_pkg;

    localparam int POS_W   = 12;   // coordinate port width
    localparam int SPEED_W = 10;   // launch speed register width
    localparam int GRAV_W  = 16;   // gravity register width, Q4.12
    localparam int ANG_W   = 16;   // output angle width, Q1.15
    localparam int ATAN_W  = 32;   // arctangent table entry width, Q.30
    localparam int NRM_BIT = 40;   // normalization target bit for the CORDIC inputs
    localparam int NRM_W   = NRM_BIT + 1;
    localparam int SH_W    = 6;    // normalizing shift amount width
    localparam int ATAN_LEN = 24;

    localparam logic [ANG_W-1:0] HALF_PI_Q15 = 16'd51472;
    localparam logic [ANG_W-1:0] ANG_MAX     = 16'hFFFF;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register index codes (byte address bit 2)
    localparam logic REG_SPEED   = 1'b0;
    localparam logic REG_GRAVITY = 1'b1;

    // atan(2^-i) in Q.30, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
        logic [ATAN_W-1:0] val;
        unique case (idx)
            5'd0:  val = 32'd843314857;
            5'd1:  val = 32'd497837830;
            5'd2:  val = 32'd263043837;
            5'd3:  val = 32'd133525159;
            5'd4:  val = 32'd67021687;
            5'd5:  val = 32'd33543516;
            5'd6:  val = 32'd16775851;
            5'd7:  val = 32'd8388437;
            5'd8:  val = 32'd4194283;
            5'd9:  val = 32'd2097149;
            5'd10: val = 32'd1048576;
            5'd11: val = 32'd524288;
            5'd12: val = 32'd262144;
            5'd13: val = 32'd131072;
            5'd14: val = 32'd65536;
            5'd15: val = 32'd32768;
            5'd16: val = 32'd16384;
            5'd17: val = 32'd8192;
            5'd18: val = 32'd4096;
            5'd19: val = 32'd2048;
            5'd20: val = 32'd1024;
            5'd21: val = 32'd512;
            5'd22: val = 32'd256;
            5'd23: val = 32'd128;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/ballistic_launch_angle.sv =====
// Launch angle to hit a target: products, discriminant, root, divide-free CORDIC arctangent.
// Pipeline order: stages A to E, the square root, stages F to H, the CORDIC, stage R, output register;
//   the root is RW bits, RW = half the discriminant width (32 at COORD_BITS = 12).
// Throughput: one item per cycle while in_stall is low; the integer square
//   root takes one bit per stage and the CORDIC one rotation per stage, all fully pipelined.
// Reset: pipeline valid bits, output and skid stages clear; speed = 20, gravity = 1.0.
module ballistic_launch_angle #(
    parameter int COORD_BITS   = 12,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bla_pkg::ADDR_W-1:0]   paddr,
    input  logic [bla_pkg::DATA_W-1:0]   pwdata,
    output logic [bla_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bla_pkg::POS_W-1:0]    shooter_x,
    input  logic [bla_pkg::POS_W-1:0]    shooter_y,
    input  logic [bla_pkg::POS_W-1:0]    target_x,
    input  logic [bla_pkg::POS_W-1:0]    target_y,
    input  logic                         high_arc,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bla_pkg::ANG_W-1:0]    launch_angle,
    output logic                         reachable,
    output logic                         vertical_shot
);
    import bla_pkg::*;

    localparam int XW   = COORD_BITS;
    localparam int V2W  = 2 * SPEED_W;
    localparam int V4W  = 2 * V2W;
    localparam int GXW  = GRAV_W + XW;
    localparam int YGW  = XW + GRAV_W;
    localparam int T1W  = 2 * GXW;
    localparam int YVW  = YGW + V2W;
    localparam int T2W  = YVW + 13;
    localparam int RHW  = ((T1W > T2W) ? T1W : T2W) + 1;
    localparam int LHW  = V4W + 24;
    localparam int MW   = (LHW > RHW) ? LHW : RHW;
    localparam int RW   = (MW + 1) / 2;
    localparam int SQW  = 2 * RW;
    localparam int REMW = RW + 2;
    localparam int NUMW = ((V2W + 12 > RW) ? V2W + 12 : RW) + 2;
    localparam int CW   = NRM_W + 4;
    localparam int ZW   = ATAN_W + 1;
    localparam int RNDW = ZW + 1;

    typedef struct packed {
        logic [V2W-1:0] v2;
        logic [GXW-1:0] gx;
        logic           x0;
        logic           high;
        logic           reach;
    } sq_side_t;

    typedef struct packed {
        logic den_zero;
        logic nonpos;
        logic reach;
        logic x0;
    } flag_t;

    // ---------------- configuration registers ----------------
    logic [SPEED_W-1:0] speed_reg;
    logic [GRAV_W-1:0]  gravity_reg;
    logic               cfg_wr;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg   <= SPEED_W'(20);
            gravity_reg <= GRAV_W'(4096);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_SPEED:   speed_reg   <= pwdata[SPEED_W-1:0];
                REG_GRAVITY: gravity_reg <= pwdata[GRAV_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SPEED:   prdata = DATA_W'(speed_reg);
            REG_GRAVITY: prdata = DATA_W'(gravity_reg);
            default:     prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic sk_valid_reg;
    logic pipe_en;

    assign pipe_en  = ~sk_valid_reg;
    assign in_stall = sk_valid_reg;

    // ---------------- stage A: absolute offsets ----------------
    logic          a_valid_reg;
    logic [XW-1:0] a_x_reg, a_y_reg;
    logic          a_high_reg;
    logic [XW-1:0] sx, sy, tx, ty;

    assign sx = XW'(shooter_x);
    assign sy = XW'(shooter_y);
    assign tx = XW'(target_x);
    assign ty = XW'(target_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (pipe_en)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_x_reg    <= (tx > sx) ? tx - sx : sx - tx;
            a_y_reg    <= (ty > sy) ? ty - sy : sy - ty;
            a_high_reg <= high_arc;
        end
    end

    // ---------------- stage B: first products ----------------
    logic           b_valid_reg;
    logic [V2W-1:0] b_v2_reg;
    logic [GXW-1:0] b_gx_reg;
    logic [YGW-1:0] b_yg_reg;
    logic           b_x0_reg, b_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (pipe_en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            b_v2_reg   <= V2W'(speed_reg) * V2W'(speed_reg);
            b_gx_reg   <= GXW'(gravity_reg) * GXW'(a_x_reg);
            b_yg_reg   <= YGW'(a_y_reg) * YGW'(gravity_reg);
            b_x0_reg   <= (a_x_reg == '0);
            b_high_reg <= a_high_reg;
        end
    end

    // ---------------- stage C: second products ----------------
    logic           c_valid_reg;
    logic [V4W-1:0] c_v4_reg;
    logic [T1W-1:0] c_gx2_reg;
    logic [YVW-1:0] c_yv_reg;
    logic [V2W-1:0] c_v2_reg;
    logic [GXW-1:0] c_gx_reg;
    logic           c_x0_reg, c_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (pipe_en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            c_v4_reg   <= V4W'(b_v2_reg) * V4W'(b_v2_reg);
            c_gx2_reg  <= T1W'(b_gx_reg) * T1W'(b_gx_reg);
            c_yv_reg   <= YVW'(b_yg_reg) * YVW'(b_v2_reg);
            c_v2_reg   <= b_v2_reg;
            c_gx_reg   <= b_gx_reg;
            c_x0_reg   <= b_x0_reg;
            c_high_reg <= b_high_reg;
        end
    end

    // ---------------- stage D: discriminant terms in Q.24 ----------------
    logic          d_valid_reg;
    logic [MW-1:0] d_lhs_reg, d_rhs_reg;
    sq_side_t      d_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (pipe_en)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            d_lhs_reg <= MW'({c_v4_reg, 24'b0});
            d_rhs_reg <= MW'(RHW'(c_gx2_reg) + (RHW'(c_yv_reg) << 13));
            d_side_reg.v2    <= c_v2_reg;
            d_side_reg.gx    <= c_gx_reg;
            d_side_reg.x0    <= c_x0_reg;
            d_side_reg.high  <= c_high_reg;
            d_side_reg.reach <= 1'b0;
        end
    end

    // ---------------- stage E: sign and magnitude ----------------
    logic          e_valid_reg;
    logic [MW-1:0] e_mag_reg;
    sq_side_t      e_side_reg;
    logic          e_reach;
    sq_side_t      e_side;

    assign e_reach = (d_lhs_reg >= d_rhs_reg);

    // side data with the reach flag filled in
    always_comb
    begin
        e_side       = d_side_reg;
        e_side.reach = e_reach;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (pipe_en)
            e_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            e_mag_reg  <= e_reach ? d_lhs_reg - d_rhs_reg : d_rhs_reg - d_lhs_reg;
            e_side_reg <= e_side;
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic            sq_valid_reg [RW];
    logic [REMW-1:0] sq_rem_reg   [RW];
    logic [RW-1:0]   sq_root_reg  [RW];
    logic [SQW-1:0]  sq_mag_reg   [RW];
    sq_side_t        sq_side_reg  [RW];

    logic [REMW-1:0] sq_src_rem   [RW];
    logic [RW-1:0]   sq_src_root  [RW];
    logic [SQW-1:0]  sq_src_mag   [RW];
    logic [REMW-1:0] sq_rem_t     [RW];
    logic [REMW-1:0] sq_trial     [RW];
    logic [REMW-1:0] sq_rem_next  [RW];
    logic [RW-1:0]   sq_root_next [RW];

    always_comb
    begin
        for (int j = 0; j < RW; j++)
        begin
            if (j == 0)
            begin
                sq_src_rem[j]  = '0;
                sq_src_root[j] = '0;
                sq_src_mag[j]  = SQW'(e_mag_reg);
            end
            else
            begin
                sq_src_rem[j]  = sq_rem_reg[j-1];
                sq_src_root[j] = sq_root_reg[j-1];
                sq_src_mag[j]  = sq_mag_reg[j-1];
            end
            sq_rem_t[j] = {sq_src_rem[j][REMW-3:0], sq_src_mag[j][2*(RW-1-j) +: 2]};
            sq_trial[j] = {sq_src_root[j], 2'b01};
            if (sq_rem_t[j] >= sq_trial[j])
            begin
                sq_rem_next[j]  = sq_rem_t[j] - sq_trial[j];
                sq_root_next[j] = {sq_src_root[j][RW-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[j]  = sq_rem_t[j];
                sq_root_next[j] = {sq_src_root[j][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < RW; j++)
                sq_valid_reg[j] <= 1'b0;
        end
        else if (pipe_en)
        begin
            sq_valid_reg[0] <= e_valid_reg;
            for (int j = 1; j < RW; j++)
                sq_valid_reg[j] <= sq_valid_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int j = 0; j < RW; j++)
            begin
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
                sq_mag_reg[j]  <= sq_src_mag[j];
            end
            sq_side_reg[0] <= e_side_reg;
            for (int j = 1; j < RW; j++)
                sq_side_reg[j] <= sq_side_reg[j-1];
        end
    end

    // ---------------- stage F: numerator and denominator ----------------
    logic                   f_valid_reg;
    logic signed [NUMW-1:0] f_num_reg;
    logic [GXW-1:0]         f_den_reg;
    flag_t                  f_flag_reg;
    logic signed [NUMW-1:0] f_base, f_root, f_num;
    sq_side_t               f_side;

    assign f_side = sq_side_reg[RW-1];
    assign f_base = NUMW'({f_side.v2, 12'b0});
    assign f_root = NUMW'(sq_root_reg[RW-1]);
    assign f_num  = f_side.high ? f_base + f_root : f_base - f_root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (pipe_en)
            f_valid_reg <= sq_valid_reg[RW-1];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            f_num_reg           <= f_num;
            f_den_reg           <= f_side.gx;
            f_flag_reg.den_zero <= (f_side.gx == '0);
            f_flag_reg.nonpos   <= f_num[NUMW-1] | (f_num == '0);
            f_flag_reg.reach    <= f_side.reach;
            f_flag_reg.x0       <= f_side.x0;
        end
    end

    // ---------------- stage G: leading one of num | den ----------------
    logic             g_valid_reg;
    logic [NRM_W-1:0] g_num_reg, g_den_reg;
    logic [SH_W-1:0]  g_sh_reg;
    flag_t            g_flag_reg;
    logic [NRM_W-1:0] g_or;
    logic [SH_W-1:0]  g_msb;

    assign g_or = NRM_W'(unsigned'(f_num_reg)) | NRM_W'(f_den_reg);

    always_comb
    begin
        g_msb = '0;
        for (int b = 0; b < NRM_W; b++)
        begin
            if (g_or[b])
                g_msb = SH_W'(b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (pipe_en)
            g_valid_reg <= f_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            g_num_reg  <= NRM_W'(unsigned'(f_num_reg));
            g_den_reg  <= NRM_W'(f_den_reg);
            g_sh_reg   <= SH_W'(NRM_BIT) - g_msb;
            g_flag_reg <= f_flag_reg;
        end
    end

    // ---------------- stage H: normalizing shift ----------------
    logic                 h_valid_reg;
    logic signed [CW-1:0] h_cx_reg, h_cy_reg;
    flag_t                h_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_valid_reg <= 1'b0;
        else if (pipe_en)
            h_valid_reg <= g_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            h_cx_reg   <= CW'(NRM_W'(g_den_reg << g_sh_reg));
            h_cy_reg   <= CW'(NRM_W'(g_num_reg << g_sh_reg));
            h_flag_reg <= g_flag_reg;
        end
    end

    // ---------------- CORDIC vectoring, one rotation per stage ----------------
    logic                 cr_valid_reg [CORDIC_STEPS];
    logic signed [CW-1:0] cr_cx_reg    [CORDIC_STEPS];
    logic signed [CW-1:0] cr_cy_reg    [CORDIC_STEPS];
    logic signed [ZW-1:0] cr_z_reg     [CORDIC_STEPS];
    flag_t                cr_flag_reg  [CORDIC_STEPS];

    logic signed [CW-1:0] cr_src_cx [CORDIC_STEPS];
    logic signed [CW-1:0] cr_src_cy [CORDIC_STEPS];
    logic signed [ZW-1:0] cr_src_z  [CORDIC_STEPS];
    logic signed [CW-1:0] cr_dx     [CORDIC_STEPS];
    logic signed [CW-1:0] cr_dy     [CORDIC_STEPS];
    logic signed [ZW-1:0] cr_ang    [CORDIC_STEPS];
    logic signed [CW-1:0] cr_cx_next [CORDIC_STEPS];
    logic signed [CW-1:0] cr_cy_next [CORDIC_STEPS];
    logic signed [ZW-1:0] cr_z_next  [CORDIC_STEPS];

    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (i == 0)
            begin
                cr_src_cx[i] = h_cx_reg;
                cr_src_cy[i] = h_cy_reg;
                cr_src_z[i]  = '0;
            end
            else
            begin
                cr_src_cx[i] = cr_cx_reg[i-1];
                cr_src_cy[i] = cr_cy_reg[i-1];
                cr_src_z[i]  = cr_z_reg[i-1];
            end
            cr_dx[i]  = cr_src_cy[i] >>> i;
            cr_dy[i]  = cr_src_cx[i] >>> i;
            cr_ang[i] = ZW'(atan_q30(5'(i)));
            if (!cr_src_cy[i][CW-1])
            begin
                cr_cx_next[i] = cr_src_cx[i] + cr_dx[i];
                cr_cy_next[i] = cr_src_cy[i] - cr_dy[i];
                cr_z_next[i]  = cr_src_z[i] + cr_ang[i];
            end
            else
            begin
                cr_cx_next[i] = cr_src_cx[i] - cr_dx[i];
                cr_cy_next[i] = cr_src_cy[i] + cr_dy[i];
                cr_z_next[i]  = cr_src_z[i] - cr_ang[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CORDIC_STEPS; i++)
                cr_valid_reg[i] <= 1'b0;
        end
        else if (pipe_en)
        begin
            cr_valid_reg[0] <= h_valid_reg;
            for (int i = 1; i < CORDIC_STEPS; i++)
                cr_valid_reg[i] <= cr_valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                cr_cx_reg[i] <= cr_cx_next[i];
                cr_cy_reg[i] <= cr_cy_next[i];
                cr_z_reg[i]  <= cr_z_next[i];
            end
            cr_flag_reg[0] <= h_flag_reg;
            for (int i = 1; i < CORDIC_STEPS; i++)
                cr_flag_reg[i] <= cr_flag_reg[i-1];
        end
    end

    // ---------------- stage R: rounding, clamping, special cases ----------------
    logic                   r_valid_reg;
    logic [ANG_W-1:0]       r_angle_reg;
    logic                   r_reach_reg, r_vert_reg;
    logic signed [RNDW-1:0] r_rnd;
    logic [RNDW-16:0]       r_q15;
    logic [ANG_W-1:0]       r_angle;
    flag_t                  r_flag;

    assign r_flag = cr_flag_reg[CORDIC_STEPS-1];
    assign r_rnd  = RNDW'(cr_z_reg[CORDIC_STEPS-1]) + RNDW'(16384);
    assign r_q15  = r_rnd[RNDW-1:15];

    always_comb
    begin
        priority if (r_flag.den_zero)
            r_angle = HALF_PI_Q15;
        else if (r_flag.nonpos || r_rnd[RNDW-1])
            r_angle = '0;
        else if (r_q15 > (RNDW-15)'(ANG_MAX))
            r_angle = ANG_MAX;
        else
            r_angle = r_q15[ANG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_valid_reg <= 1'b0;
        else if (pipe_en)
            r_valid_reg <= cr_valid_reg[CORDIC_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            r_angle_reg <= r_angle;
            r_reach_reg <= r_flag.reach;
            r_vert_reg  <= r_flag.x0;
        end
    end

    // ---------------- output register with skid stage ----------------
    logic             out_valid_reg, out_valid_next, sk_valid_next;
    logic [ANG_W-1:0] out_angle_reg, sk_angle_reg;
    logic             out_reach_reg, sk_reach_reg;
    logic             out_vert_reg, sk_vert_reg;
    logic             take, o_free, load_from_sk, load_from_pipe, load_sk;

    assign take   = out_valid_reg & ~out_stall;
    assign o_free = ~out_valid_reg | take;

    always_comb
    begin
        load_from_sk   = sk_valid_reg & take;
        load_from_pipe = ~sk_valid_reg & r_valid_reg & o_free;
        load_sk        = ~sk_valid_reg & r_valid_reg & ~o_free;
        out_valid_next = out_valid_reg;
        sk_valid_next  = sk_valid_reg;
        if (load_from_sk)
            sk_valid_next = 1'b0;
        if (load_sk)
            sk_valid_next = 1'b1;
        if (load_from_sk || load_from_pipe)
            out_valid_next = 1'b1;
        else if (take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sk_valid_reg  <= sk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_sk)
        begin
            out_angle_reg <= sk_angle_reg;
            out_reach_reg <= sk_reach_reg;
            out_vert_reg  <= sk_vert_reg;
        end
        else if (load_from_pipe)
        begin
            out_angle_reg <= r_angle_reg;
            out_reach_reg <= r_reach_reg;
            out_vert_reg  <= r_vert_reg;
        end
        if (load_sk)
        begin
            sk_angle_reg <= r_angle_reg;
            sk_reach_reg <= r_reach_reg;
            sk_vert_reg  <= r_vert_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign launch_angle  = out_angle_reg;
    assign reachable     = out_reach_reg;
    assign vertical_shot = out_vert_reg;

endmodule
